// ===== rtl/core/chunked_memory_read_deframer_top_defines.svh =====
// Assertion macros shared by the deframer checker.
`ifndef CHUNKED_MEMORY_READ_DEFRAMER_TOP_DEFINES_SVH
`define CHUNKED_MEMORY_READ_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on aclk and held off during reset.
`define CMRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, clocked on aclk and held off during reset.
`define CMRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ===== rtl/core/cmrd_pkg.sv =====
// Types, codes and helper functions of the chunked memory read deframer.
package cmrd_pkg;

    localparam logic [7:0] CHUNK_MAX = 8'd64;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_RX    = 1'b1;

    localparam logic [7:0] MARK_REQ = 8'h52;
    localparam logic [7:0] MARK_RSP = 8'h57;
    localparam logic [7:0] MARK_ACK = 8'h06;

    localparam logic [2:0] ST_CHUNK_OK   = 3'd0;
    localparam logic [2:0] ST_DONE       = 3'd1;
    localparam logic [2:0] ST_BAD_MARKER = 3'd2;
    localparam logic [2:0] ST_MISMATCH   = 3'd3;
    localparam logic [2:0] ST_CHECKSUM   = 3'd4;

    typedef enum logic [1:0] {
        KIND_REQ    = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    // Length of the next chunk from the bytes still to read and the limit register.
    function automatic logic [7:0] cmrd_chunk_len(input logic [31:0] left,
                                                  input logic [7:0] limit);
        logic [7:0] lim;
        lim = (limit == 8'd0 || limit > CHUNK_MAX) ? CHUNK_MAX : limit;
        return (left < {24'd0, lim}) ? left[7:0] : lim;
    endfunction

endpackage

// ===== rtl/core/chunked_memory_read_deframer_top.sv =====
// Top level of the chunked memory read deframer.
// A start request (tuser 0) opens a read of total_bytes bytes at start_addr and issues
// six request bytes per chunk; received bytes (tuser 1) are parsed as reply frames,
// data bytes come out with their addresses and a status follows each frame. Requests
// are checked combinationally; the single result port then sets the rate: a request
// that yields n results (0 or 1 for most received bytes, 1 or 6 for a start, up to 7 at the
// end of a frame) holds the input until they have left, and the next request is taken in the
// cycle its last result leaves, so single-result bytes flow at one per cycle while m_tready is high.
module chunked_memory_read_deframer_top
    import cmrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,     // chunk_limit

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,      // start_addr[31:0], total_bytes[63:32], rx_byte[71:64]
    input  logic        s_tuser,      // cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // out_byte[7:0], byte_addr[39:8], status[42:40], zero
    output logic [1:0]  m_tuser,      // kind
    output logic        m_tlast
);

    logic [31:0] in_start_addr;
    logic [31:0] in_total;
    logic [7:0]  in_byte;
    logic        s_fire;
    logic        m_fire;

    logic [7:0]  cfg_reg;
    logic        busy_reg,  busy_next;
    logic [8:0]  pos_reg,   pos_next;
    logic [31:0] addr_reg,  addr_next;
    logic [31:0] left_reg,  left_next;
    logic [7:0]  len_reg,   len_next;
    logic [7:0]  sum_reg,   sum_next;
    logic        mbad_reg,  mbad_next;
    logic        ebad_reg,  ebad_next;

    logic        st_pend_reg;
    logic [2:0]  st_code_reg;
    logic        dat_pend_reg;
    logic [7:0]  dat_byte_reg;
    logic [31:0] dat_addr_reg;
    logic        req_pend_reg;
    logic [2:0]  req_idx_reg;
    logic [31:0] req_addr_reg;
    logic [7:0]  req_len_reg;

    logic        st_new;
    logic [2:0]  st_code_new;
    logic        dat_new;
    logic [7:0]  dat_addr_byte;
    logic [31:0] dat_addr_new;
    logic        req_new;
    logic [31:0] req_addr_new;

    logic [8:0]  end_pos;
    logic [7:0]  echo_byte;
    logic        mark_bad_now;
    logic [31:0] adv_addr;
    logic [31:0] adv_left;

    kind_t       out_kind;
    logic [7:0]  out_byte;
    logic [31:0] out_addr;
    logic [2:0]  out_status;
    logic        out_last;
    logic [7:0]  req_byte;

    assign in_start_addr = s_tdata[31:0];
    assign in_total      = s_tdata[63:32];
    assign in_byte       = s_tdata[71:64];

    assign cfg_ready = 1'b1;
    assign m_tvalid  = st_pend_reg | dat_pend_reg | req_pend_reg;
    assign s_tready  = !m_tvalid || (m_tready && out_last);
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;

    assign end_pos  = 9'd6 + {1'b0, len_reg};
    assign adv_addr = addr_reg + {24'd0, len_reg};
    assign adv_left = left_reg - {24'd0, len_reg};
    assign mark_bad_now = mbad_reg || (in_byte != MARK_ACK);
    assign dat_addr_byte = 8'(pos_reg - 9'd6);
    assign dat_addr_new  = addr_reg + {24'd0, dat_addr_byte};

    always_comb begin
        unique case (pos_reg[2:0])
            3'd1:    echo_byte = addr_reg[31:24];
            3'd2:    echo_byte = addr_reg[23:16];
            3'd3:    echo_byte = addr_reg[15:8];
            default: echo_byte = addr_reg[7:0];
        endcase
    end

    // Frame parser and transfer state, evaluated for the request at the input.
    always_comb begin
        busy_next    = busy_reg;
        pos_next     = pos_reg;
        addr_next    = addr_reg;
        left_next    = left_reg;
        len_next     = len_reg;
        sum_next     = sum_reg;
        mbad_next    = mbad_reg;
        ebad_next    = ebad_reg;
        st_new       = 1'b0;
        st_code_new  = ST_CHUNK_OK;
        dat_new      = 1'b0;
        req_new      = 1'b0;
        req_addr_new = addr_reg;

        if (s_tuser == CMD_START) begin
            addr_next = in_start_addr;
            left_next = in_total;
            pos_next  = 9'd0;
            if (in_total == 32'd0) begin
                busy_next   = 1'b0;
                st_new      = 1'b1;
                st_code_new = ST_DONE;
            end else begin
                busy_next    = 1'b1;
                len_next     = cmrd_chunk_len(in_total, cfg_reg);
                sum_next     = 8'd0;
                mbad_next    = 1'b0;
                ebad_next    = 1'b0;
                req_new      = 1'b1;
                req_addr_new = in_start_addr;
            end
        end else if (busy_reg) begin
            pos_next = pos_reg + 9'd1;
            priority if (pos_reg == 9'd0) begin
                if (in_byte != MARK_RSP) begin
                    mbad_next = 1'b1;
                end
            end else if (pos_reg <= 9'd4) begin
                if (in_byte != echo_byte) begin
                    ebad_next = 1'b1;
                end
                sum_next = sum_reg + in_byte;
            end else if (pos_reg == 9'd5) begin
                if (in_byte != len_reg) begin
                    ebad_next = 1'b1;
                end
                sum_next = sum_reg + in_byte;
            end else if (pos_reg < end_pos) begin
                sum_next = sum_reg + in_byte;
                dat_new  = 1'b1;
            end else if (pos_reg == end_pos) begin
                sum_next = sum_reg - in_byte;
            end else begin
                pos_next  = 9'd0;
                busy_next = 1'b0;
                mbad_next = mark_bad_now;
                st_new    = 1'b1;
                priority if (mark_bad_now) begin
                    st_code_new = ST_BAD_MARKER;
                end else if (ebad_reg) begin
                    st_code_new = ST_MISMATCH;
                end else if (sum_reg != 8'd0) begin
                    st_code_new = ST_CHECKSUM;
                end else begin
                    addr_next = adv_addr;
                    left_next = adv_left;
                    if (adv_left == 32'd0) begin
                        st_code_new = ST_DONE;
                    end else begin
                        st_code_new  = ST_CHUNK_OK;
                        busy_next    = 1'b1;
                        len_next     = cmrd_chunk_len(adv_left, cfg_reg);
                        sum_next     = 8'd0;
                        mbad_next    = 1'b0;
                        ebad_next    = 1'b0;
                        req_new      = 1'b1;
                        req_addr_new = adv_addr;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg  <= 8'd0;
            busy_reg <= 1'b0;
            pos_reg  <= 9'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cfg_reg <= cfg_data;
            end
            if (s_fire) begin
                busy_reg <= busy_next;
                pos_reg  <= pos_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            addr_reg <= addr_next;
            left_reg <= left_next;
            len_reg  <= len_next;
            sum_reg  <= sum_next;
            mbad_reg <= mbad_next;
            ebad_reg <= ebad_next;
        end
    end

    // Result buffer: loaded when a request is taken, drained one result per cycle while m_tready is high.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_pend_reg  <= 1'b0;
            dat_pend_reg <= 1'b0;
            req_pend_reg <= 1'b0;
            req_idx_reg  <= 3'd0;
        end else if (s_fire) begin
            st_pend_reg  <= st_new;
            dat_pend_reg <= dat_new;
            req_pend_reg <= req_new;
            req_idx_reg  <= 3'd0;
        end else if (m_fire) begin
            priority if (st_pend_reg) begin
                st_pend_reg <= 1'b0;
            end else if (dat_pend_reg) begin
                dat_pend_reg <= 1'b0;
            end else if (req_idx_reg == 3'd5) begin
                req_pend_reg <= 1'b0;
                req_idx_reg  <= 3'd0;
            end else begin
                req_idx_reg <= req_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st_code_reg  <= st_code_new;
            dat_byte_reg <= in_byte;
            dat_addr_reg <= dat_addr_new;
            req_addr_reg <= req_addr_new;
            req_len_reg  <= len_next;
        end
    end

    always_comb begin
        unique case (req_idx_reg)
            3'd0:    req_byte = MARK_REQ;
            3'd1:    req_byte = req_addr_reg[31:24];
            3'd2:    req_byte = req_addr_reg[23:16];
            3'd3:    req_byte = req_addr_reg[15:8];
            3'd4:    req_byte = req_addr_reg[7:0];
            default: req_byte = req_len_reg;
        endcase
    end

    always_comb begin
        priority if (st_pend_reg) begin
            out_kind   = KIND_STATUS;
            out_byte   = 8'd0;
            out_addr   = 32'd0;
            out_status = st_code_reg;
            out_last   = !req_pend_reg;
        end else if (dat_pend_reg) begin
            out_kind   = KIND_DATA;
            out_byte   = dat_byte_reg;
            out_addr   = dat_addr_reg;
            out_status = ST_CHUNK_OK;
            out_last   = !req_pend_reg;
        end else begin
            out_kind   = KIND_REQ;
            out_byte   = req_byte;
            out_addr   = 32'd0;
            out_status = ST_CHUNK_OK;
            out_last   = (req_idx_reg == 3'd5);
        end
    end

    assign m_tdata = {5'd0, out_status, out_addr, out_byte};
    assign m_tuser = out_kind;
    assign m_tlast = out_last;

endmodule

// ===== rtl/core/cmrd_checker.sv =====
// Port-level checker for the chunked memory read deframer and its bind.
`include "chunked_memory_read_deframer_top_defines.svh"

module cmrd_checker
    import cmrd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    logic        out_stall;
    logic        is_status;
    logic        is_req;
    logic [50:0] out_word;

    assign out_stall = m_tvalid && !m_tready;
    assign is_status = m_tvalid && (m_tuser == KIND_STATUS);
    assign is_req    = m_tvalid && (m_tuser == KIND_REQ);
    assign out_word  = {m_tlast, m_tuser, m_tdata};

    `CMRD_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word))
    `CMRD_ASSERT_NOW(a_in_stall_busy, !s_tready, m_tvalid)
    `CMRD_ASSERT_NOW(a_status_clean, is_status, m_tdata[39:0] == 40'd0 && m_tdata[47:43] == 5'd0)
    `CMRD_ASSERT_NOW(a_req_clean, is_req, m_tdata[47:8] == 40'd0)

endmodule

bind chunked_memory_read_deframer_top cmrd_checker u_cmrd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/chunked_memory_read_deframer_checker.sv =====
// Checker for the chunked memory read deframer: predicts every output and compares.
`timescale 1ns / 1ps

module chunked_memory_read_deframer_checker
    import cmrd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,     // chunk_limit

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,      // start_addr[31:0], total_bytes[63:32], rx_byte[71:64]
    input  logic        s_tuser,      // cmd

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,      // out_byte[7:0], byte_addr[39:8], status[42:40], zero
    input  logic [1:0]  m_tuser,      // kind
    input  logic        m_tlast,

    output int          fail_count,
    output int          pending
);

    typedef struct {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [31:0] byte_addr;
        logic [2:0]  status;
        logic        last;
    } deframer_output_t;

    deframer_output_t predicted_outputs[$];

    logic [7:0]  limit_reg;
    logic        busy;
    int unsigned frame_pos;
    logic [31:0] cur_addr;
    logic [31:0] bytes_left;
    logic [7:0]  chunk_len;
    logic [7:0]  running_sum;
    logic        marker_bad;
    logic        echo_bad;

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("%0t deframer mismatch: %s", $time, what);
    endtask

    function automatic void push_output(input kind_t kind, input logic [7:0] value,
                                        input logic [31:0] addr, input logic [2:0] st);
        deframer_output_t item;
        item.kind      = kind;
        item.out_byte  = value;
        item.byte_addr = addr;
        item.status    = st;
        item.last      = 1'b0;
        predicted_outputs.push_back(item);
    endfunction

    function automatic void issue_chunk_request();
        logic [7:0] lim;
        lim = (limit_reg == 8'd0 || limit_reg > CHUNK_MAX) ? CHUNK_MAX : limit_reg;
        chunk_len = (bytes_left < {24'd0, lim}) ? bytes_left[7:0] : lim;
        push_output(KIND_REQ, MARK_REQ, 32'd0, ST_CHUNK_OK);
        push_output(KIND_REQ, cur_addr[31:24], 32'd0, ST_CHUNK_OK);
        push_output(KIND_REQ, cur_addr[23:16], 32'd0, ST_CHUNK_OK);
        push_output(KIND_REQ, cur_addr[15:8], 32'd0, ST_CHUNK_OK);
        push_output(KIND_REQ, cur_addr[7:0], 32'd0, ST_CHUNK_OK);
        push_output(KIND_REQ, chunk_len, 32'd0, ST_CHUNK_OK);
        busy        = 1'b1;
        frame_pos   = 0;
        running_sum = 8'd0;
        marker_bad  = 1'b0;
        echo_bad    = 1'b0;
    endfunction

    function automatic void predict_request(input logic cmd, input logic [31:0] addr,
                                            input logic [31:0] total, input logic [7:0] rx);
        int unsigned first;
        int unsigned pos;
        deframer_output_t tail;
        first = predicted_outputs.size();
        if (cmd == CMD_START) begin
            cur_addr   = addr;
            bytes_left = total;
            if (total == 32'd0) begin
                busy      = 1'b0;
                frame_pos = 0;
                push_output(KIND_STATUS, 8'd0, 32'd0, ST_DONE);
            end else begin
                issue_chunk_request();
            end
        end else if (busy) begin
            pos       = frame_pos;
            frame_pos = pos + 1;
            if (pos == 0) begin
                if (rx != MARK_RSP) marker_bad = 1'b1;
            end else if (pos <= 4) begin
                if (cur_addr[8 * (4 - pos) +: 8] != rx) echo_bad = 1'b1;
                running_sum += rx;
            end else if (pos == 5) begin
                if (rx != chunk_len) echo_bad = 1'b1;
                running_sum += rx;
            end else if (pos < 6 + chunk_len) begin
                running_sum += rx;
                push_output(KIND_DATA, rx, cur_addr + (pos - 6), ST_CHUNK_OK);
            end else if (pos == 6 + chunk_len) begin
                running_sum -= rx;
            end else begin
                frame_pos = 0;
                busy      = 1'b0;
                if (rx != MARK_ACK) marker_bad = 1'b1;
                if (marker_bad) begin
                    push_output(KIND_STATUS, 8'd0, 32'd0, ST_BAD_MARKER);
                end else if (echo_bad) begin
                    push_output(KIND_STATUS, 8'd0, 32'd0, ST_MISMATCH);
                end else if (running_sum != 8'd0) begin
                    push_output(KIND_STATUS, 8'd0, 32'd0, ST_CHECKSUM);
                end else begin
                    cur_addr   = cur_addr + chunk_len;
                    bytes_left = bytes_left - chunk_len;
                    if (bytes_left == 32'd0) begin
                        push_output(KIND_STATUS, 8'd0, 32'd0, ST_DONE);
                    end else begin
                        push_output(KIND_STATUS, 8'd0, 32'd0, ST_CHUNK_OK);
                        issue_chunk_request();
                    end
                end
            end
        end
        if (predicted_outputs.size() > first) begin
            tail      = predicted_outputs.pop_back();
            tail.last = 1'b1;
            predicted_outputs.push_back(tail);
        end
    endfunction

    task automatic check_output();
        deframer_output_t want;
        if (predicted_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected output kind %0d byte %02h status %0d",
                                      m_tuser, m_tdata[7:0], m_tdata[42:40]));
        end else begin
            want = predicted_outputs.pop_front();
            if (m_tuser !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
            if (m_tdata[7:0] !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h",
                                          m_tdata[7:0], want.out_byte));
            if (m_tdata[39:8] !== want.byte_addr)
                report_mismatch($sformatf("byte_addr %08h, want %08h",
                                          m_tdata[39:8], want.byte_addr));
            if (m_tdata[42:40] !== want.status)
                report_mismatch($sformatf("status %0d, want %0d",
                                          m_tdata[42:40], want.status));
            if (m_tlast !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count  = 0;
            limit_reg   = 8'd0;
            busy        = 1'b0;
            frame_pos   = 0;
            cur_addr    = 32'd0;
            bytes_left  = 32'd0;
            chunk_len   = 8'd0;
            running_sum = 8'd0;
            marker_bad  = 1'b0;
            echo_bad    = 1'b0;
            predicted_outputs.delete();
        end else begin
            if (m_tvalid && m_tready) check_output();
            if (cfg_valid && cfg_ready) limit_reg = cfg_data;
            if (s_tvalid && s_tready) begin
                predict_request(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[71:64]);
            end
        end
        pending <= predicted_outputs.size();
    end

endmodule

// ===== tb/tb_chunked_memory_read_deframer_top.sv =====
// Testbench top for the chunked memory read deframer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_chunked_memory_read_deframer_top;
    import cmrd_pkg::*;

    localparam int ITEM_TARGET = 280;
    localparam int PHASE_ITEMS = 28;
    localparam int HOLD_CYCLES = 400;

    localparam int FAULT_OPEN  = 1;
    localparam int FAULT_ADDR  = 2;
    localparam int FAULT_LEN   = 4;
    localparam int FAULT_SUM   = 8;
    localparam int FAULT_CLOSE = 16;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data  = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic [71:0] s_tdata   = 72'd0;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;

    logic        cfg_ready;
    logic        s_tready;
    logic        m_tvalid;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending;

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned hold_go   = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    int          counted_items = 0;
    int          phase         = 0;
    int          phase_mark    = 0;
    logic [7:0]  chunk_limit_set = 8'd0;
    logic        xfer_open  = 1'b0;
    logic [31:0] xfer_addr  = 32'd0;
    logic [31:0] xfer_left  = 32'd0;
    logic [7:0]  xfer_chunk = 8'd0;

    logic [7:0] limit_plan[10] = '{8'd3, 8'd0, 8'd255, 8'd1, 8'd64,
                                   8'd65, 8'd2, 8'd5, 8'd128, 8'd7};

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    chunked_memory_read_deframer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    chunked_memory_read_deframer_checker deframer_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // The receiver either stalls at random or sits out a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic [31:0] addr,
                             input logic [31:0] total, input logic [7:0] rx);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {rx, total, addr};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_START || xfer_open) counted_items++;
    endtask

    task automatic send_rx(input logic [7:0] value);
        send_item(CMD_RX, $urandom, $urandom, value);
    endtask

    function automatic logic [7:0] next_chunk_len();
        logic [7:0] lim;
        lim = (chunk_limit_set == 8'd0 || chunk_limit_set > CHUNK_MAX) ? CHUNK_MAX
                                                                        : chunk_limit_set;
        return (xfer_left < {24'd0, lim}) ? xfer_left[7:0] : lim;
    endfunction

    task automatic send_start(input logic [31:0] addr, input logic [31:0] total);
        send_item(CMD_START, addr, total, $urandom);
        xfer_open = (total != 32'd0);
        xfer_addr = addr;
        xfer_left = total;
        if (xfer_open) xfer_chunk = next_chunk_len();
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        chunk_limit_set = value;
    endtask

    // Sends one reply frame for the outstanding request; cut_at below zero sends it whole.
    task automatic send_reply_frame(input int faults, input int cut_at);
        logic [7:0] frame_bytes[$];
        logic [7:0] value;
        logic [7:0] sum;
        int         bad_addr_idx;
        int         sent;
        sum = 8'd0;
        bad_addr_idx = $urandom_range(3);
        value = MARK_RSP;
        if (faults & FAULT_OPEN) value ^= 8'($urandom_range(255, 1));
        frame_bytes.push_back(value);
        for (int i = 0; i < 4; i++) begin
            value = xfer_addr[8 * (3 - i) +: 8];
            if ((faults & FAULT_ADDR) && i == bad_addr_idx) value ^= 8'($urandom_range(255, 1));
            frame_bytes.push_back(value);
            sum += value;
        end
        value = xfer_chunk;
        if (faults & FAULT_LEN) value ^= 8'($urandom_range(255, 1));
        frame_bytes.push_back(value);
        sum += value;
        for (int i = 0; i < xfer_chunk; i++) begin
            value = $urandom;
            frame_bytes.push_back(value);
            sum += value;
        end
        if (faults & FAULT_SUM) sum ^= 8'($urandom_range(255, 1));
        frame_bytes.push_back(sum);
        value = MARK_ACK;
        if (faults & FAULT_CLOSE) value ^= 8'($urandom_range(255, 1));
        frame_bytes.push_back(value);

        sent = 0;
        foreach (frame_bytes[i]) begin
            if (cut_at >= 0 && sent >= cut_at) break;
            send_rx(frame_bytes[i]);
            sent++;
        end
        if (cut_at < 0) begin
            if (faults != 0) begin
                xfer_open = 1'b0;
            end else begin
                xfer_addr = xfer_addr + xfer_chunk;
                xfer_left = xfer_left - xfer_chunk;
                if (xfer_left == 32'd0) xfer_open = 1'b0;
                else xfer_chunk = next_chunk_len();
            end
        end
    endtask

    task automatic next_phase();
        int unsigned mode;
        write_limit(limit_plan[phase % 10]);
        mode = phase % 4;
        case (mode)
            0: begin
                sender_idle_pct = 0;
                recv_stall_pct <= 0;
            end
            1: begin
                sender_idle_pct = 59;
                recv_stall_pct <= 0;
            end
            2: begin
                sender_idle_pct = 0;
                recv_stall_pct <= 59;
            end
            default: begin
                sender_idle_pct = 16;
                recv_stall_pct <= 16;
            end
        endcase
        if (phase == 2) hold_go <= hold_go + 1;
        phase++;
        phase_mark += PHASE_ITEMS;
    endtask

    task automatic run_transfer();
        logic [31:0] addr;
        logic [31:0] total;
        int unsigned pick;
        int          chunks;
        int          faults;
        int          room;
        pick = $urandom_range(5);
        addr = (pick == 0) ? 32'hFFFF_FFF0 + $urandom_range(15) : $urandom;
        pick = $urandom_range(99);
        if (pick < 5) total = 32'd0;
        else if (pick < 12) total = $urandom;
        else if (pick < 20) total = $urandom_range(130, 20);
        else total = $urandom_range(12, 1);
        send_start(addr, total);
        chunks = 0;
        while (xfer_open) begin
            if (counted_items >= phase_mark) next_phase();
            room = ITEM_TARGET - counted_items;
            if (room < int'(xfer_chunk) + 8) begin
                send_reply_frame(0, (room > 0) ? room : 0);
                break;
            end
            if (chunks >= 4 || $urandom_range(99) < 6) begin
                send_reply_frame(0, $urandom_range(xfer_chunk + 7));
                break;
            end
            faults = ($urandom_range(99) < 80) ? 0 : $urandom_range(31, 1);
            send_reply_frame(faults, -1);
            chunks++;
        end
        if (!xfer_open && $urandom_range(9) == 0) begin
            repeat ($urandom_range(2, 1)) send_rx($urandom);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        write_limit(8'd1);

        send_start(32'h1234_5678, 32'd0);
        send_rx(8'hA5);
        send_start(32'hFFFF_FFFF, 32'd2);
        send_reply_frame(0, -1);
        send_reply_frame(FAULT_OPEN | FAULT_ADDR | FAULT_SUM, -1);
        send_start(32'h8000_0000, 32'hFFFF_FFFF);
        send_start(32'h0000_0000, 32'd0);

        while (counted_items < ITEM_TARGET) begin
            if (counted_items >= phase_mark) next_phase();
            run_transfer();
        end

        settle();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
